// ===== sv/hvt_pkg.sv =====
// Shared item types and result codes of the header value tokenizer.
package hvt_pkg;

    // Where a character goes.
    localparam logic [1:0] DEST_DROP  = 2'd0;
    localparam logic [1:0] DEST_NAME  = 2'd1;
    localparam logic [1:0] DEST_VALUE = 2'd2;

    // Commit events.
    localparam logic [2:0] EV_NONE        = 3'd0;
    localparam logic [2:0] EV_PUSH_NAMED  = 3'd1;
    localparam logic [2:0] EV_PUSH_KEYED  = 3'd2;
    localparam logic [2:0] EV_COMMIT_PARAM = 3'd3;
    localparam logic [2:0] EV_NAME_TO_KEY = 3'd4;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       last;
    } hvt_char_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] dest;
        logic [2:0] event_res;
        logic       error;
        logic       done_res;
        logic       end_mark;
    } hvt_token_t;

endpackage

// ===== sv/hvt_char_if.sv =====
// Input channel: one header value character per item.
interface hvt_char_if
    import hvt_pkg::*;
;
    logic      valid;
    logic      ready;
    hvt_char_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/hvt_token_if.sv =====
// Output channel: one tokenizer result per item.
interface hvt_token_if
    import hvt_pkg::*;
;
    logic       valid;
    logic       ready;
    hvt_token_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/hvt_in_stage.sv =====
// Input register of the tokenizer: holds one character until it is parsed.
module hvt_in_stage
    import hvt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    hvt_char_if.sink   chars,
    input  logic       advance,
    output logic       item_valid,
    output hvt_char_t  item
);

    logic      valid_reg;
    logic      valid_next;
    hvt_char_t data_reg;
    logic      take;

    // Refill in the same cycle the held item moves on.
    assign chars.ready = !valid_reg || advance;
    assign take        = chars.valid && chars.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            data_reg <= chars.data;
        end
    end

    assign item_valid = valid_reg;
    assign item       = data_reg;

endmodule

// ===== sv/hvt_parse.sv =====
// Parse state and per-character decision logic of the tokenizer.
module hvt_parse
    import hvt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       advance,
    input  hvt_char_t  item,
    output hvt_token_t token
);

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    typedef enum logic [11:0] {
        ST_FIELD_START = 12'b0000_0000_0001,
        ST_FIELD       = 12'b0000_0000_0010,
        ST_FIELD_Q     = 12'b0000_0000_0100,
        ST_KEY_START   = 12'b0000_0000_1000,
        ST_KEY         = 12'b0000_0001_0000,
        ST_KEY_Q       = 12'b0000_0010_0000,
        ST_VALUE_START = 12'b0000_0100_0000,
        ST_VALUE       = 12'b0000_1000_0000,
        ST_VALUE_Q     = 12'b0001_0000_0000,
        ST_SKIP_QUOTE  = 12'b0010_0000_0000,
        ST_SKIP_SPACE  = 12'b0100_0000_0000,
        ST_ERR         = 12'b1000_0000_0000
    } pstate_t;

    typedef struct packed {
        pstate_t    st;
        pstate_t    nx;
        logic       again;
        logic       bad;
        logic [1:0] dest;
        logic [2:0] ev;
        logic       new_esc;
    } pass_t;

    // One decision step; start and space-skip states hand on to a further step.
    function automatic pass_t step_pass(pstate_t st, pstate_t nx, logic [7:0] c, logic esc);
        pass_t r;
        logic  sep;
        r         = '0;
        r.st      = st;
        r.nx      = nx;
        sep       = (c == CH_SEMI) || (c == CH_COMMA);
        unique case (st)
            ST_FIELD_START:
            begin
                if (c == CH_QUOTE) r.st = ST_FIELD_Q;
                else begin r.st = ST_FIELD; r.again = 1'b1; end
            end
            ST_KEY_START:
            begin
                if (c == CH_QUOTE) r.st = ST_KEY_Q;
                else begin r.st = ST_KEY; r.again = 1'b1; end
            end
            ST_VALUE_START:
            begin
                if (c == CH_QUOTE) r.st = ST_VALUE_Q;
                else begin r.st = ST_VALUE; r.again = 1'b1; end
            end
            ST_FIELD:
            begin
                if (sep)
                begin
                    r.ev = EV_PUSH_NAMED;
                    r.st = ST_SKIP_SPACE;
                    r.nx = (c == CH_SEMI) ? ST_KEY_START : ST_FIELD_START;
                end
                else if (c == CH_EQ)
                begin
                    r.ev = EV_PUSH_KEYED;
                    r.st = ST_SKIP_SPACE;
                    r.nx = ST_VALUE_START;
                end
                else r.dest = DEST_NAME;
            end
            ST_KEY:
            begin
                if (c == CH_EQ)
                begin
                    r.st = ST_SKIP_SPACE;
                    r.nx = ST_VALUE_START;
                end
                else r.dest = DEST_NAME;
            end
            ST_VALUE:
            begin
                if (sep)
                begin
                    r.ev = EV_COMMIT_PARAM;
                    r.st = ST_SKIP_SPACE;
                    r.nx = (c == CH_SEMI) ? ST_KEY_START : ST_FIELD_START;
                end
                else r.dest = DEST_VALUE;
            end
            ST_FIELD_Q, ST_KEY_Q, ST_VALUE_Q:
            begin
                if (esc) r.dest = (st == ST_VALUE_Q) ? DEST_VALUE : DEST_NAME;
                else if (c == CH_QUOTE)
                begin
                    if (st == ST_FIELD_Q)
                    begin
                        r.ev = EV_PUSH_NAMED;
                        r.nx = ST_FIELD_START;
                    end
                    else if (st == ST_KEY_Q) r.nx = ST_KEY_START;
                    else
                    begin
                        r.ev = EV_COMMIT_PARAM;
                        r.nx = ST_VALUE_START;
                    end
                    r.st = ST_SKIP_QUOTE;
                end
                else if (c == CH_BSLASH) r.new_esc = 1'b1;
                else r.dest = (st == ST_VALUE_Q) ? DEST_VALUE : DEST_NAME;
            end
            ST_SKIP_QUOTE:
            begin
                if (c == CH_SPACE) r.st = st;
                else if (sep)
                begin
                    if (nx == ST_FIELD_START || nx == ST_VALUE_START)
                    begin
                        r.st = (c == CH_COMMA) ? ST_FIELD_START : ST_KEY_START;
                        r.nx = ST_ERR;
                    end
                    else r.bad = 1'b1;
                end
                else if (c == CH_EQ)
                begin
                    if (nx == ST_KEY_START || nx == ST_FIELD_START)
                    begin
                        if (nx == ST_FIELD_START) r.ev = EV_NAME_TO_KEY;
                        r.st = ST_VALUE_START;
                        r.nx = ST_ERR;
                    end
                    else r.bad = 1'b1;
                end
                else r.bad = 1'b1;
            end
            ST_SKIP_SPACE:
            begin
                if (c != CH_SPACE)
                begin
                    r.st    = nx;
                    r.nx    = ST_ERR;
                    r.again = 1'b1;
                end
            end
            default: r.bad = 1'b1;
        endcase
        return r;
    endfunction

    pstate_t state_reg, state_next;
    pstate_t after_reg, after_next;
    logic    esc_reg, esc_next;
    logic    err_reg, err_next;

    always_comb
    begin
        pass_t      r;
        pstate_t    st;
        pstate_t    nx;
        logic       again;
        logic       bad;
        logic [1:0] dest;
        logic [2:0] ev;
        logic       new_esc;
        logic       err;
        logic       done;

        st      = state_reg;
        nx      = after_reg;
        again   = 1'b1;
        bad     = 1'b0;
        dest    = DEST_DROP;
        ev      = EV_NONE;
        new_esc = 1'b0;
        done    = 1'b0;

        // At most four chained steps: space skip, start, then the text state.
        for (int i = 0; i < 4; i++)
        begin
            if (again && !bad)
            begin
                r       = step_pass(st, nx, item.in_byte, esc_reg);
                st      = r.st;
                nx      = r.nx;
                again   = r.again;
                bad     = r.bad;
                dest    = dest | r.dest;
                ev      = ev | r.ev;
                new_esc = new_esc | r.new_esc;
            end
        end

        // Drop the character and park in the error state.
        if (bad)
        begin
            st      = ST_ERR;
            dest    = DEST_DROP;
            ev      = EV_NONE;
            new_esc = 1'b0;
        end
        err = err_reg || bad;

        // Apply the final commit on the last character.
        if (item.last)
        begin
            if (st == ST_FIELD) ev = EV_PUSH_NAMED;
            else if (st == ST_VALUE) ev = EV_COMMIT_PARAM;
            else if (st != ST_SKIP_QUOTE) err = 1'b1;
            done = !err;
        end

        token.out_byte  = item.in_byte;
        token.dest      = dest;
        token.event_res = ev;
        token.error     = err;
        token.done_res  = done;
        token.end_mark  = item.last;

        if (item.last)
        begin
            state_next = ST_FIELD_START;
            after_next = ST_ERR;
            esc_next   = 1'b0;
            err_next   = 1'b0;
        end
        else
        begin
            state_next = st;
            after_next = nx;
            esc_next   = new_esc;
            err_next   = err;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_FIELD_START;
            after_reg <= ST_ERR;
            esc_reg   <= 1'b0;
            err_reg   <= 1'b0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
            after_reg <= after_next;
            esc_reg   <= esc_next;
            err_reg   <= err_next;
        end
    end

endmodule

// ===== sv/hvt_out_stage.sv =====
// Result register of the tokenizer: holds one result until it is taken.
module hvt_out_stage
    import hvt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    hvt_token_if.source tokens,
    input  logic       load,
    input  hvt_token_t token,
    output logic       free
);

    logic       valid_reg;
    logic       valid_next;
    hvt_token_t data_reg;

    // Room when empty or when the held result leaves this cycle.
    assign free = !valid_reg || tokens.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (tokens.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= token;
        end
    end

    assign tokens.valid = valid_reg;
    assign tokens.data  = data_reg;

endmodule

// ===== sv/header_value_tokenizer.sv =====
// Top level of the header value tokenizer: input register, parser, result register.
//
// Tokenizes an HTTP header value of the form entry[;key=value]*[,entry...], where any
// entry, key or value may be double-quoted with backslash escapes inside the quotes.
// Feed the value one character per item on chars, with last set on its final character;
// each item yields exactly one result item on tokens, in order. A result echoes the
// character and says where it goes (dropped, name/key text, value text), flags entry and
// parameter commits, carries a sticky syntax error flag, and on the last character
// reports accept (done_res) or reject and returns the parser to its reset state for the
// next value. Throughput is one item per clock while tokens.ready stays high: the whole
// per-character decision (up to four chained parse steps) settles between the input
// register and the result register. A result is loaded into the result register when its
// character moves on from the input register, which waits while the result register is
// full; the input stays ready while a result waits, as long as the result register can drain or is empty.
module header_value_tokenizer
    import hvt_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    hvt_char_if.sink     chars,
    hvt_token_if.source  tokens
);

    logic       item_valid;
    hvt_char_t  item;
    hvt_token_t token;
    logic       free;
    logic       advance;

    // Move the held character through the parser when the result register has room.
    assign advance = item_valid && free;

    hvt_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .chars      (chars),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    // Parser state advances only together with a result load.
    hvt_parse u_parse (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (item),
        .token   (token)
    );

    hvt_out_stage u_out_stage (
        .clk    (clk),
        .rst_n  (rst_n),
        .tokens (tokens),
        .load   (advance),
        .token  (token),
        .free   (free)
    );

endmodule

// ===== sim/header_value_tokenizer_checker.sv =====
// Result checker for the header value tokenizer: predicts every result item and compares it.
`timescale 1ns / 1ps
module header_value_tokenizer_checker
    import hvt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    hvt_char_if  chars,
    hvt_token_if tokens,
    output int   fail_count,
    output int   pending_count,
    output int   tokens_checked,
    output int   values_accepted,
    output int   values_rejected
);

    localparam logic [7:0] QUOTE_CHAR     = 8'h22;
    localparam logic [7:0] SEMI_CHAR      = 8'h3B;
    localparam logic [7:0] COMMA_CHAR     = 8'h2C;
    localparam logic [7:0] EQUAL_CHAR     = 8'h3D;
    localparam logic [7:0] BACKSLASH_CHAR = 8'h5C;
    localparam logic [7:0] SPACE_CHAR     = 8'h20;
    localparam int         REPORT_LIMIT   = 10;

    typedef enum logic [3:0] {
        PS_FIELD_START = 4'd0,
        PS_FIELD       = 4'd1,
        PS_FIELD_Q     = 4'd2,
        PS_KEY_START   = 4'd3,
        PS_KEY         = 4'd4,
        PS_KEY_Q       = 4'd5,
        PS_VALUE_START = 4'd6,
        PS_VALUE       = 4'd7,
        PS_VALUE_Q     = 4'd8,
        PS_SKIP_QUOTE  = 4'd9,
        PS_SKIP_SPACE  = 4'd10,
        PS_ERROR       = 4'd11
    } parse_t;

    // Predicted parser state.
    parse_t     tok_state;
    parse_t     space_next_state;
    logic       esc_armed;
    logic       err_sticky;

    hvt_token_t expected_tokens[$];
    hvt_token_t exp_tok;

    function automatic void clear_parser();
        tok_state        = PS_FIELD_START;
        space_next_state = PS_ERROR;
        esc_armed        = 1'b0;
        err_sticky       = 1'b0;
    endfunction

    // Print one mismatching result item against its prediction.
    function automatic void report_mismatch(input int idx, input hvt_token_t want,
                                            input hvt_token_t got);
        $display("result %0d expected: byte %h dest %0d event %0d err %b done %b end %b",
                 idx, want.out_byte, want.dest, want.event_res, want.error,
                 want.done_res, want.end_mark);
        $display("result %0d got:      byte %h dest %0d event %0d err %b done %b end %b",
                 idx, got.out_byte, got.dest, got.event_res, got.error,
                 got.done_res, got.end_mark);
    endfunction

    // Advance the predicted parser by one character and return its result item.
    function automatic hvt_token_t predict_token(input hvt_char_t ch);
        logic [7:0] c;
        parse_t     st;
        parse_t     nx;
        logic       esc_next;
        logic       bad;
        logic       again;
        logic [1:0] dest;
        logic [1:0] text_dest;
        logic [2:0] ev;
        int         pass;
        hvt_token_t tok;

        c        = ch.in_byte;
        st       = tok_state;
        nx       = space_next_state;
        esc_next = 1'b0;
        bad      = 1'b0;
        again    = 1'b1;
        dest     = DEST_DROP;
        ev       = EV_NONE;
        for (pass = 0; pass < 4 && again && !bad; pass++)
        begin
            again = 1'b0;
            case (st)
                PS_FIELD_START:
                begin
                    st    = (c == QUOTE_CHAR) ? PS_FIELD_Q : PS_FIELD;
                    again = (c != QUOTE_CHAR);
                end
                PS_KEY_START:
                begin
                    st    = (c == QUOTE_CHAR) ? PS_KEY_Q : PS_KEY;
                    again = (c != QUOTE_CHAR);
                end
                PS_VALUE_START:
                begin
                    st    = (c == QUOTE_CHAR) ? PS_VALUE_Q : PS_VALUE;
                    again = (c != QUOTE_CHAR);
                end
                PS_FIELD:
                begin
                    if (c == SEMI_CHAR || c == COMMA_CHAR)
                    begin
                        ev = EV_PUSH_NAMED;
                        st = PS_SKIP_SPACE;
                        nx = (c == SEMI_CHAR) ? PS_KEY_START : PS_FIELD_START;
                    end
                    else if (c == EQUAL_CHAR)
                    begin
                        ev = EV_PUSH_KEYED;
                        st = PS_SKIP_SPACE;
                        nx = PS_VALUE_START;
                    end
                    else
                        dest = DEST_NAME;
                end
                PS_KEY:
                begin
                    if (c == EQUAL_CHAR)
                    begin
                        st = PS_SKIP_SPACE;
                        nx = PS_VALUE_START;
                    end
                    else
                        dest = DEST_NAME;
                end
                PS_VALUE:
                begin
                    if (c == SEMI_CHAR || c == COMMA_CHAR)
                    begin
                        ev = EV_COMMIT_PARAM;
                        st = PS_SKIP_SPACE;
                        nx = (c == SEMI_CHAR) ? PS_KEY_START : PS_FIELD_START;
                    end
                    else
                        dest = DEST_VALUE;
                end
                PS_FIELD_Q, PS_KEY_Q, PS_VALUE_Q:
                begin
                    text_dest = (st == PS_VALUE_Q) ? DEST_VALUE : DEST_NAME;
                    if (esc_armed)
                        dest = text_dest;
                    else if (c == QUOTE_CHAR)
                    begin
                        if (st == PS_FIELD_Q)
                        begin
                            ev = EV_PUSH_NAMED;
                            nx = PS_FIELD_START;
                        end
                        else if (st == PS_KEY_Q)
                            nx = PS_KEY_START;
                        else
                        begin
                            ev = EV_COMMIT_PARAM;
                            nx = PS_VALUE_START;
                        end
                        st = PS_SKIP_QUOTE;
                    end
                    else if (c == BACKSLASH_CHAR)
                        esc_next = 1'b1;
                    else
                        dest = text_dest;
                end
                PS_SKIP_QUOTE:
                begin
                    if (c == COMMA_CHAR || c == SEMI_CHAR)
                    begin
                        if (nx == PS_FIELD_START || nx == PS_VALUE_START)
                        begin
                            st = (c == COMMA_CHAR) ? PS_FIELD_START : PS_KEY_START;
                            nx = PS_ERROR;
                        end
                        else
                            bad = 1'b1;
                    end
                    else if (c == EQUAL_CHAR)
                    begin
                        if (nx == PS_KEY_START || nx == PS_FIELD_START)
                        begin
                            if (nx == PS_FIELD_START)
                                ev = EV_NAME_TO_KEY;
                            st = PS_VALUE_START;
                            nx = PS_ERROR;
                        end
                        else
                            bad = 1'b1;
                    end
                    else if (c != SPACE_CHAR)
                        bad = 1'b1;
                end
                PS_SKIP_SPACE:
                begin
                    if (c != SPACE_CHAR)
                    begin
                        st    = nx;
                        nx    = PS_ERROR;
                        again = 1'b1;
                    end
                end
                default:
                    bad = 1'b1;
            endcase
        end

        if (bad)
        begin
            st         = PS_ERROR;
            dest       = DEST_DROP;
            ev         = EV_NONE;
            esc_next   = 1'b0;
            err_sticky = 1'b1;
        end
        tok_state        = st;
        space_next_state = nx;
        esc_armed        = esc_next;

        tok = '0;
        if (ch.last)
        begin
            if (st == PS_FIELD)
                ev = EV_PUSH_NAMED;
            else if (st == PS_VALUE)
                ev = EV_COMMIT_PARAM;
            else if (st != PS_SKIP_QUOTE)
                err_sticky = 1'b1;
            tok.done_res = !err_sticky;
        end
        tok.out_byte  = c;
        tok.dest      = dest;
        tok.event_res = ev;
        tok.error     = err_sticky;
        tok.end_mark  = ch.last;
        if (ch.last)
            clear_parser();
        return tok;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_parser();
            expected_tokens.delete();
            fail_count      = 0;
            pending_count   = 0;
            tokens_checked  = 0;
            values_accepted = 0;
            values_rejected = 0;
        end
        else
        begin
            // Check the output first: a result never leaves in the cycle its character enters.
            if (tokens.valid && tokens.ready)
            begin
                if (expected_tokens.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("result item with nothing expected: byte %h dest %0d event %0d",
                                 tokens.data.out_byte, tokens.data.dest, tokens.data.event_res);
                end
                else
                begin
                    exp_tok = expected_tokens.pop_front();
                    tokens_checked++;
                    if (exp_tok.end_mark)
                    begin
                        if (exp_tok.done_res)
                            values_accepted++;
                        else
                            values_rejected++;
                    end
                    if (tokens.data.out_byte  !== exp_tok.out_byte  ||
                        tokens.data.dest      !== exp_tok.dest      ||
                        tokens.data.event_res !== exp_tok.event_res ||
                        tokens.data.error     !== exp_tok.error     ||
                        tokens.data.done_res  !== exp_tok.done_res  ||
                        tokens.data.end_mark  !== exp_tok.end_mark)
                    begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT)
                            report_mismatch(tokens_checked, exp_tok, tokens.data);
                    end
                end
            end
            if (chars.valid && chars.ready)
                expected_tokens = {expected_tokens, predict_token(chars.data)};
            pending_count = expected_tokens.size();
        end
    end

endmodule

// ===== sim/header_value_tokenizer_tb.sv =====
// Testbench top for the header value tokenizer: stimulus, flow control and verdict.
`timescale 1ns / 1ps
module header_value_tokenizer_tb
    import hvt_pkg::*;
;

    typedef logic [7:0] text_q_t[$];

    // Characters with a meaning to the parser.
    localparam logic [7:0] QUOTE_CHAR     = 8'h22;
    localparam logic [7:0] SEMI_CHAR      = 8'h3B;
    localparam logic [7:0] COMMA_CHAR     = 8'h2C;
    localparam logic [7:0] EQUAL_CHAR     = 8'h3D;
    localparam logic [7:0] BACKSLASH_CHAR = 8'h5C;
    localparam logic [7:0] SPACE_CHAR     = 8'h20;

    localparam int RANDOM_CHARS = 1150;
    // A result passes the input and result registers; leave a margin for strays.
    localparam int TAIL_CYCLES  = 8;

    logic clk;
    logic rst_n;

    int fail_count;
    int pending_count;
    int tokens_checked;
    int values_accepted;
    int values_rejected;
    int chars_sent;
    int values_sent;

    hvt_char_if  chars_if();
    hvt_token_if tokens_if();

    header_value_tokenizer u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .chars  (chars_if),
        .tokens (tokens_if)
    );

    header_value_tokenizer_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .chars           (chars_if),
        .tokens          (tokens_if),
        .fail_count      (fail_count),
        .pending_count   (pending_count),
        .tokens_checked  (tokens_checked),
        .values_accepted (values_accepted),
        .values_rejected (values_rejected)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Add one character at the end of a text.
    function automatic void append_char(ref text_q_t q, input logic [7:0] b);
        q = {q, b};
    endfunction

    // Pick a parser-significant character most of the time, else any byte.
    function automatic logic [7:0] special_char();
        case ($urandom_range(0, 6))
            0: return QUOTE_CHAR;
            1: return SEMI_CHAR;
            2: return COMMA_CHAR;
            3: return EQUAL_CHAR;
            4: return BACKSLASH_CHAR;
            5: return SPACE_CHAR;
            default: return 8'($urandom());
        endcase
    endfunction

    // Text character that keeps the value well formed: inside quotes anything but a
    // quote or backslash, outside quotes anything but a quote, a separator or '='. Lean on
    // lowercase letters so values look like headers, but let every byte through.
    function automatic logic [7:0] text_char(input bit quoted);
        logic [7:0] b;
        do
            b = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(8'h61, 8'h7a)) : 8'($urandom());
        while (quoted ? (b == QUOTE_CHAR || b == BACKSLASH_CHAR)
                      : (b == QUOTE_CHAR || b == SEMI_CHAR || b == COMMA_CHAR ||
                         b == EQUAL_CHAR));
        return b;
    endfunction

    // Spaces that the parser skips after a separator or a closing quote.
    function automatic void add_spaces(ref text_q_t q);
        if ($urandom_range(0, 2) == 0)
            repeat ($urandom_range(1, 2)) append_char(q, SPACE_CHAR);
    endfunction

    // Append one name, key or value: a plain token or a quoted string with escapes.
    function automatic void add_text(ref text_q_t q);
        int n;
        if ($urandom_range(0, 2) == 0)
        begin
            append_char(q, QUOTE_CHAR);
            n = $urandom_range(0, 5);
            repeat (n)
            begin
                if ($urandom_range(0, 4) == 0)
                begin
                    // Escaped byte: favor an escaped quote or backslash.
                    append_char(q, BACKSLASH_CHAR);
                    append_char(q, $urandom_range(0, 1) ? special_char() : 8'($urandom()));
                end
                else
                    append_char(q, text_char(1'b1));
            end
            append_char(q, QUOTE_CHAR);
            add_spaces(q);
        end
        else
        begin
            n = $urandom_range(1, 6);
            repeat (n) append_char(q, text_char(1'b0));
        end
    endfunction

    // Well-formed value: entries split by commas, each with an optional direct value
    // (name=value) and up to two key=value parameters.
    function automatic void build_value(ref text_q_t q);
        int entries;
        int params;
        entries = $urandom_range(1, 3);
        for (int e = 0; e < entries; e++)
        begin
            if (e > 0)
            begin
                append_char(q, COMMA_CHAR);
                add_spaces(q);
            end
            add_text(q);
            if ($urandom_range(0, 3) == 0)
            begin
                append_char(q, EQUAL_CHAR);
                add_spaces(q);
                add_text(q);
            end
            params = $urandom_range(0, 2);
            repeat (params)
            begin
                append_char(q, SEMI_CHAR);
                add_spaces(q);
                add_text(q);
                append_char(q, EQUAL_CHAR);
                add_spaces(q);
                add_text(q);
            end
        end
    endfunction

    function automatic text_q_t to_text(input string s);
        text_q_t q;
        for (int i = 0; i < s.len(); i++)
            append_char(q, s[i]);
        return q;
    endfunction

    // Drive one header value, one character per item, last set on the final one.
    // Change inputs at the falling edge only; an item is taken at the rising edge that
    // sees valid and ready together. A source gap of zero keeps valid high across items
    // so valid is never dropped and raised in one step.
    task automatic send_value(input text_q_t text);
        hvt_char_t ch;
        int        gap;
        logic      src_burst;
        src_burst = ($urandom_range(0, 3) == 0);
        foreach (text[i])
        begin
            ch.in_byte = text[i];
            ch.last    = (i == text.size() - 1);
            gap = src_burst ? 0 : $urandom_range(0, 7);
            if (gap > 0)
            begin
                chars_if.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            chars_if.data  <= ch;
            chars_if.valid <= 1'b1;
            do
                @(posedge clk);
            while (!chars_if.ready);
            @(negedge clk);
            chars_sent++;
        end
        values_sent++;
    endtask

    // Result side: stall ready for a random count of cycles, then hold it high until
    // one result item is taken. Toggle into and out of stretches with no stall at all.
    initial
    begin
        int   stall;
        logic sink_burst;
        tokens_if.ready <= 1'b0;
        sink_burst = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            if ($urandom_range(0, 15) == 0)
                sink_burst = !sink_burst;
            stall = sink_burst ? 0 : $urandom_range(0, 7);
            if (stall > 0)
            begin
                tokens_if.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            tokens_if.ready <= 1'b1;
            do
                @(posedge clk);
            while (!tokens_if.valid);
            @(negedge clk);
        end
    end

    // Hard stop, many times the slowest legal run.
    initial
    begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        text_q_t text;
        int      directed_chars;
        int      mode;
        int      idx;
        int      n;

        chars_sent  = 0;
        values_sent = 0;
        rst_n          <= 1'b0;
        chars_if.valid <= 1'b0;
        chars_if.data  <= '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed values.
        // Plain entry with a quoted key and a quoted value: name push, commit on the
        // closing quote, accepted from the skip state after it.
        send_value(to_text("a;\"k\"=\"v\""));
        // Quoted entry holding an escaped quote, then '=': entry name becomes the key,
        // plain value committed at the end.
        send_value(to_text("\"\\\"\"=1"));
        // Byte extremes in a plain name, then '=': unnamed entry keeps its text as key.
        text = '{8'hFF, 8'h00, EQUAL_CHAR, 8'h76};
        send_value(text);
        // Junk after a closing quote: syntax error, sticky for the rest of the value.
        send_value(to_text("\"a\"x,"));
        // Value ends right after a separator: unexpected end, rejected.
        send_value(to_text("a;"));
        // Value ends with an escape still pending inside quotes: rejected.
        send_value(to_text("\"\\"));
        directed_chars = chars_sent;

        // Random values: mostly well formed, some broken by a bad character or cut
        // short, some pure noise weighted toward the separators.
        while (chars_sent - directed_chars < RANDOM_CHARS)
        begin
            text.delete();
            mode = $urandom_range(0, 19);
            if (mode < 17)
            begin
                build_value(text);
                if (mode >= 14)
                begin
                    idx = $urandom_range(0, text.size() - 1);
                    if ($urandom_range(0, 1) == 0)
                        text = text[0:idx];
                    else
                        text[idx] = special_char();
                end
            end
            else
            begin
                n = $urandom_range(1, 12);
                repeat (n)
                    append_char(text, $urandom_range(0, 1) ? special_char() : 8'($urandom()));
            end
            send_value(text);
        end
        chars_if.valid <= 1'b0;

        // Drain: wait for every predicted result, then a TAIL_CYCLES margin for strays.
        wait (pending_count == 0);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d characters in %0d header values, %0d of them directed.",
                 chars_sent, values_sent, directed_chars);
        $display("Checked %0d result items: %0d values accepted, %0d rejected, %0d failures.",
                 tokens_checked, values_accepted, values_rejected, fail_count);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
